>>> hw/rtl/column_average_edge_detector_macros.svh
// Assertion macros shared by the edge detector's checker.
`ifndef COLUMN_AVERAGE_EDGE_DETECTOR_MACROS_SVH
`define COLUMN_AVERAGE_EDGE_DETECTOR_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define CAED_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CAED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/caed_pkg.sv
// Shared constants, widths and helpers of the column average edge detector.
package caed_pkg;

   // Sizes
   localparam int STORE_DEPTH_DEF = 1024;
   localparam int PIX_W         = 8;
   localparam int SUM_W         = 10;
   localparam int ROW_W         = 12;
   localparam int OUT_COL_W     = 10;
   localparam int FW_W          = 11;
   localparam int THR_W         = 8;
   localparam int MIN_DIM       = 3;

   // Result packing: edge_value, out_row, out_col, then zero fill
   localparam int RSP_DATA_W    = 32;
   localparam int RSP_EDGE_LSB  = 0;
   localparam int RSP_ROW_LSB   = RSP_EDGE_LSB + PIX_W;
   localparam int RSP_COL_LSB   = RSP_ROW_LSB + ROW_W;
   localparam int RSP_PAD_W     = RSP_DATA_W - RSP_COL_LSB - OUT_COL_W;

   // Configuration port
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 12;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT    = 2'd2;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd50;
   localparam logic [FW_W-1:0]  WIDTH_RESET     = 11'd640;
   localparam logic [ROW_W-1:0] HEIGHT_RESET    = 12'd480;

   localparam logic [PIX_W-1:0] EDGE_ON  = 8'hFF;
   localparam logic [PIX_W-1:0] EDGE_OFF = 8'h00;

   // Divide by 3 as multiply by 683 / 2048; exact for sums up to 765
   localparam int DIV3_MUL   = 683;
   localparam int DIV3_SHIFT = 11;
   localparam int DIV3_PW    = SUM_W + 10;

   function automatic logic [PIX_W-1:0] div3(input logic [SUM_W-1:0] s);
      logic [DIV3_PW-1:0] p;
      p = DIV3_PW'(s) * DIV3_PW'(DIV3_MUL);
      return p[DIV3_SHIFT +: PIX_W];
   endfunction

endpackage

>>> hw/rtl/caed_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module caed_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

>>> hw/rtl/column_average_edge_detector.sv
// Top level of the column average edge detector.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  req     | in        | req_tvalid/tready  | tdata: pixel_value; tuser: frame_start
//  rsp     | out       | rsp_tvalid/tready  | tdata: edge_value, out_row, out_col;
//          |           |                    | tlast: frame_last
//  csr     | in        | csr_valid/ready    | csr_index, csr_data (always ready)
//
//  One pixel per clock unless rsp stalls; results pass the s1, s2 and output registers.
//  Stages: read issue of the line-store RAM, sum and divide, compare, output register.
//  The line-store RAM (one read, one write per cycle) sets the one-pixel-per-clock rate.
//  Reset clears counters, column history, stage valids and config; the RAM has no clear.
//  A stalled rsp fills the stages one by one before req_tready drops.
module column_average_edge_detector #(
   parameter int STORE_DEPTH = caed_pkg::STORE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [caed_pkg::PIX_W-1:0]         req_tdata,   // [7:0] pixel_value
   input  logic                               req_tuser,   // [0] frame_start
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [caed_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [7:0] edge_value,
                                                           // [19:8] out_row,
                                                           // [29:20] out_col
   output logic                               rsp_tlast,   // frame_last
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [caed_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [caed_pkg::CSR_DATA_W-1:0]    csr_data
);

   import caed_pkg::*;

   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int WCNT_W = ($clog2(STORE_DEPTH + 1) > FW_W) ? $clog2(STORE_DEPTH + 1) : FW_W;
   localparam int LINE_W = 2 * PIX_W;
   localparam logic [WCNT_W-1:0] MAX_W_L = WCNT_W'(STORE_DEPTH);
   localparam logic [WCNT_W-1:0] MIN_W_L = WCNT_W'(MIN_DIM);
   localparam logic [ROW_W-1:0]  MIN_H_L = ROW_W'(MIN_DIM);
   localparam logic [ROW_W-1:0]  ROW_2   = ROW_W'(2);
   localparam logic [ADDR_W-1:0] COL_2   = ADDR_W'(2);

   typedef struct packed {
      logic [PIX_W-1:0]     pix;
      logic [ADDR_W-1:0]    addr;
      logic                 emit;
      logic                 last;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
      logic                 fwd;
      logic [LINE_W-1:0]    fwd_line;
   } s1_type;

   typedef struct packed {
      logic [PIX_W-1:0]     avg_l;
      logic [PIX_W-1:0]     avg_r;
      logic                 emit;
      logic                 last;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
   } s2_type;

   typedef struct packed {
      logic [PIX_W-1:0]     edge_val;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
      logic                 last;
   } out_type;

   // Configuration registers
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [FW_W-1:0]   fw_ff, fw_in;
   logic [ROW_W-1:0]  fh_ff, fh_in;

   // Counters and column history (stored as column averages)
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [PIX_W-1:0]  hist0_ff, hist0_in, hist1_ff, hist1_in;

   // Pipeline
   logic    s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, out_v_ff, out_v_in;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   out_type out_ff, out_in;

   logic                en1, en2, en_out, accept, s1_adv;
   logic [WCNT_W-1:0]   fw_ext, w_eff, col_ext, col_next;
   logic [ROW_W-1:0]    h_eff, cur_row;
   logic [ROW_W:0]      row_next;
   logic [ADDR_W-1:0]   cur_col;
   logic [WCNT_W-1:0]   col_m1;
   logic [LINE_W-1:0]   rd_line, line;
   logic [SUM_W-1:0]    sum;
   logic [PIX_W-1:0]    avg_r, diff;

   // Stage enables: each stage moves when the one after it is free or moving
   assign en_out     = !out_v_ff || rsp_tready;
   assign en2        = !s2_v_ff || en_out;
   assign en1        = !s1_v_ff || en2;
   assign req_tready = en1;
   assign accept     = req_tvalid && en1;
   assign s1_adv     = s1_v_ff && en2;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      fw_in  = fw_ff;
      fh_in  = fh_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_THRESHOLD: thr_in = csr_data[THR_W-1:0];
            REG_WIDTH:     fw_in  = csr_data[FW_W-1:0];
            REG_HEIGHT:    fh_in  = csr_data[ROW_W-1:0];
            default:       ;
         endcase
      end
   end

   // Effective frame size, clamped
   always_comb begin
      fw_ext = WCNT_W'(fw_ff);
      if (fw_ext < MIN_W_L) begin
         w_eff = MIN_W_L;
      end else if (fw_ext > MAX_W_L) begin
         w_eff = MAX_W_L;
      end else begin
         w_eff = fw_ext;
      end
      h_eff = (fh_ff < MIN_H_L) ? MIN_H_L : fh_ff;
   end

   // Stage 0: position of the incoming pixel, counter advance, RAM read
   always_comb begin
      cur_row  = req_tuser ? '0 : row_ff;
      cur_col  = req_tuser ? '0 : col_ff;
      col_ext  = WCNT_W'(cur_col);
      col_next = col_ext + WCNT_W'(1);
      row_next = {1'b0, cur_row} + (ROW_W + 1)'(1);
      col_m1   = col_ext - WCNT_W'(1);

      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_next >= w_eff) begin
            col_in = '0;
            row_in = (row_next >= {1'b0, h_eff}) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[ADDR_W-1:0];
            row_in = cur_row;
         end
      end

      s1_v_in = en1 ? accept : s1_v_ff;
      s1_in   = s1_ff;
      if (accept) begin
         s1_in.pix  = req_tdata;
         s1_in.addr = cur_col;
         s1_in.emit = (cur_row >= ROW_2) && (cur_col >= COL_2)
                      && (cur_row < h_eff) && (col_ext < w_eff);
         s1_in.last = (cur_row == h_eff - ROW_W'(1)) && (col_ext == w_eff - WCNT_W'(1));
         s1_in.row  = cur_row - ROW_W'(1);
         s1_in.col  = col_m1[OUT_COL_W-1:0];
         // Same entry as the write going out this cycle: take the new data
         s1_in.fwd      = s1_v_ff && (s1_ff.addr == cur_col);
         s1_in.fwd_line = {line[PIX_W-1:0], s1_ff.pix};
      end
   end

   // Line store: upper row in the high byte, middle row in the low byte
   caed_ram #(
      .WIDTH (LINE_W),
      .DEPTH (STORE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_ff.addr),
      .wr_data ({line[PIX_W-1:0], s1_ff.pix}),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (rd_line)
   );

   // Stage 1: column sum, average, line-store write back, history shift
   always_comb begin
      line  = s1_ff.fwd ? s1_ff.fwd_line : rd_line;
      sum   = SUM_W'(line[LINE_W-1:PIX_W]) + SUM_W'(line[PIX_W-1:0]) + SUM_W'(s1_ff.pix);
      avg_r = div3(sum);

      hist0_in = hist0_ff;
      hist1_in = hist1_ff;
      if (s1_adv) begin
         hist1_in = hist0_ff;
         hist0_in = avg_r;
      end

      s2_v_in = en2 ? s1_v_ff : s2_v_ff;
      s2_in   = s2_ff;
      if (s1_adv) begin
         s2_in.avg_l = hist1_ff;
         s2_in.avg_r = avg_r;
         s2_in.emit  = s1_ff.emit;
         s2_in.last  = s1_ff.last;
         s2_in.row   = s1_ff.row;
         s2_in.col   = s1_ff.col;
      end
   end

   // Stage 2: threshold compare into the output register
   always_comb begin
      diff = (s2_ff.avg_l > s2_ff.avg_r) ? (s2_ff.avg_l - s2_ff.avg_r)
                                         : (s2_ff.avg_r - s2_ff.avg_l);
      out_v_in = en_out ? (s2_v_ff && s2_ff.emit) : out_v_ff;
      out_in   = out_ff;
      if (en_out && s2_v_ff) begin
         out_in.edge_val = (diff > thr_ff) ? EDGE_ON : EDGE_OFF;
         out_in.row      = s2_ff.row;
         out_in.col      = s2_ff.col;
         out_in.last     = s2_ff.last;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THRESHOLD_RESET;
         fw_ff    <= WIDTH_RESET;
         fh_ff    <= HEIGHT_RESET;
         row_ff   <= '0;
         col_ff   <= '0;
         hist0_ff <= '0;
         hist1_ff <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         thr_ff   <= thr_in;
         fw_ff    <= fw_in;
         fh_ff    <= fh_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         hist0_ff <= hist0_in;
         hist1_ff <= hist1_in;
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_ff.col, out_ff.row, out_ff.edge_val};
   assign rsp_tlast  = out_ff.last;

endmodule

>>> hw/rtl/caed_checker.sv
// Port-level checker for the column average edge detector, bound to the top level.
`include "column_average_edge_detector_macros.svh"

module caed_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [caed_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   import caed_pkg::*;

   logic [PIX_W-1:0]     edge_val;
   logic [ROW_W-1:0]     out_row;
   logic [OUT_COL_W-1:0] out_col;
   logic                 req_txn;

   assign edge_val = rsp_tdata[RSP_EDGE_LSB +: PIX_W];
   assign out_row  = rsp_tdata[RSP_ROW_LSB +: ROW_W];
   assign out_col  = rsp_tdata[RSP_COL_LSB +: OUT_COL_W];
   assign req_txn  = req_tvalid && req_tready;

   // A result held back by the consumer keeps its contents
   `CAED_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp changed while stalled")

   // Edge marks are all-zero or all-one
   `CAED_ASSERT(a_edge_code, clock, reset, rsp_tvalid |-> (edge_val == EDGE_ON || edge_val == EDGE_OFF), "edge_value not 0 or 255")

   // Only interior pixels leave the block
   `CAED_ASSERT(a_interior, clock, reset, rsp_tvalid |-> (out_row != '0 && out_col != '0), "border pixel emitted")

   // Reset empties the pipeline; nothing comes out in the cycle after
   `CAED_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result right after reset")

   // Just out of reset, no result comes with back-to-back pixel transfers
   `CAED_ASSERT(a_no_early, clock, reset, $past(reset) |-> !rsp_tvalid || !req_txn || !$past(req_txn), "result without enough history")

endmodule

bind column_average_edge_detector caed_checker u_caed_checker (.*);

>>> bench/tb_top.sv
// Self-checking bench for the column average edge detector, driven with directed and random frames.
`timescale 1ns / 1ps

module tb_top;
   import caed_pkg::*;

   localparam int LINE_DEPTH   = STORE_DEPTH_DEF;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int SMALL_DIM    = 12;
   localparam int REPORT_MAX   = 10;
   localparam int INTRO_WIDTH  = 5;
   localparam int INTRO_ROWS   = 12;

   typedef struct packed {
      logic [PIX_W-1:0] level;
      logic             sof;
   } pixel_item_t;

   typedef struct packed {
      logic [PIX_W-1:0]     edge_val;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
      logic                 last_px;
   } edge_result_t;

   // DUT ports, all inputs known from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata  = '0;   // [7:0] pixel_value
   logic                  req_tuser  = 1'b0; // [0] frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [7:0] edge_value, [19:8] out_row, [29:20] out_col
   logic                  rsp_tlast;         // frame_last
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   // Stimulus and expectation stores
   pixel_item_t  pixel_q[$];
   edge_result_t edge_expect_q[$];
   int           send_idle_pct  = 0;
   int           recv_idle_pct  = 0;
   logic         req_taken      = 1'b0;
   int           mismatch_count = 0;
   int           cycle_count    = 0;
   logic [PIX_W-1:0] column_level [LINE_DEPTH];

   // Predictor state: two line stores, last two column sums, raster position, settings
   logic [PIX_W-1:0] line_two_up [LINE_DEPTH];
   logic [PIX_W-1:0] line_one_up [LINE_DEPTH];
   logic [SUM_W-1:0] colsum_prev [2];
   logic [ROW_W-1:0]     cur_row;
   logic [OUT_COL_W-1:0] cur_col;
   logic [THR_W-1:0]     thr_setting;
   logic [FW_W-1:0]      width_setting;
   logic [ROW_W-1:0]     height_setting;

   always #5 clock = ~clock;

   column_average_edge_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Sizes as the block applies them
   function automatic int eff_width(input logic [FW_W-1:0] raw);
      int w;
      w = raw;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      return w;
   endfunction

   function automatic int eff_height(input logic [ROW_W-1:0] raw);
      int h;
      h = raw;
      if (h < MIN_DIM) h = MIN_DIM;
      return h;
   endfunction

   // One accepted pixel: emit the decision for (row-1, col-1) when interior, then shift state
   function automatic void predict_edge_pixel(input logic [PIX_W-1:0] pix, input logic sof);
      int w, h, r, c, colsum, avg_left, avg_right, diff;
      edge_result_t res;
      w = eff_width(width_setting);
      h = eff_height(height_setting);
      if (sof) begin
         cur_row = '0;
         cur_col = '0;
      end
      r = cur_row;
      c = cur_col;
      colsum = int'(line_two_up[c]) + int'(line_one_up[c]) + int'(pix);
      if (r >= 2 && c >= 2 && r < h && c < w) begin
         avg_left  = int'(colsum_prev[1]) / 3;
         avg_right = colsum / 3;
         diff = (avg_left > avg_right) ? avg_left - avg_right : avg_right - avg_left;
         res.edge_val = (diff > int'(thr_setting)) ? EDGE_ON : EDGE_OFF;
         res.row      = ROW_W'(r - 1);
         res.col      = OUT_COL_W'(c - 1);
         res.last_px  = (r == h - 1) && (c == w - 1);
         edge_expect_q.insert(edge_expect_q.size(), res);
      end
      line_two_up[c] = line_one_up[c];
      line_one_up[c] = pix;
      colsum_prev[1] = colsum_prev[0];
      colsum_prev[0] = SUM_W'(colsum);
      // raster advance, wrapping at the end of a row and of a frame
      if (c + 1 >= w) begin
         cur_col = '0;
         cur_row = (r + 1 >= h) ? '0 : ROW_W'(r + 1);
      end else begin
         cur_col = OUT_COL_W'(c + 1);
      end
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_THRESHOLD: thr_setting    = data[THR_W-1:0];
         REG_WIDTH:     width_setting  = data[FW_W-1:0];
         REG_HEIGHT:    height_setting = data[ROW_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("MISMATCH: %s", msg);
   endfunction

   // Compare one result transaction against the oldest pending decision
   function automatic void check_edge_result(input logic [RSP_DATA_W-1:0] data,
                                             input logic last_px);
      edge_result_t got, want;
      logic [RSP_PAD_W-1:0] fill;
      got.edge_val = data[RSP_EDGE_LSB +: PIX_W];
      got.row      = data[RSP_ROW_LSB +: ROW_W];
      got.col      = data[RSP_COL_LSB +: OUT_COL_W];
      got.last_px  = last_px;
      fill         = data[RSP_COL_LSB + OUT_COL_W +: RSP_PAD_W];
      if (edge_expect_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result edge %0h row %0d col %0d last %0b",
                                   got.edge_val, got.row, got.col, got.last_px));
         return;
      end
      want = edge_expect_q.pop_front();
      if (got !== want || fill !== '0)
         report_mismatch($sformatf(
            "exp/got edge %0h/%0h row %0d/%0d col %0d/%0d last %0b/%0b fill %0h",
            want.edge_val, got.edge_val, want.row, got.row, want.col, got.col,
            want.last_px, got.last_px, fill));
   endfunction

   // Sampling at the rising edge: predict accepted pixels, check accepted results, watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset) begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) predict_edge_pixel(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) check_edge_result(rsp_tdata, rsp_tlast);
      end
   end

   // Pixel driver and result back-pressure, changing at the falling edge
   always @(negedge clock) begin
      pixel_item_t item;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = pixel_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= item.level;
               req_tuser  <= item.sof;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void push_pixel(input logic [PIX_W-1:0] level, input logic sof);
      pixel_item_t it;
      it.level = level;
      it.sof   = sof;
      pixel_q.insert(pixel_q.size(), it);
   endfunction

   // Nine pixels of a 3x3 frame, first listed pixel first
   function automatic void push_frame3(input logic [9*PIX_W-1:0] px, input logic sof);
      for (int k = 0; k < 9; k++) push_pixel(px[9*PIX_W-1-PIX_W*k -: PIX_W], sof && k == 0);
   endfunction

   // Block until every pixel went in and every decision came out, then let the pipe settle
   task automatic wait_drained();
      while (pixel_q.size() != 0 || req_tvalid || edge_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [THR_W-1:0] thr, input logic [FW_W-1:0] w_raw,
                            input logic [ROW_W-1:0] h_raw, input int n_items,
                            input bit sof_first, input int style, input int noise_pct);
      pixel_item_t it;
      int w, frame_len, gc, v;
      bit aligned;
      aligned = sof_first || (cur_row == 0 && cur_col == 0);
      gc = sof_first ? 0 : int'(cur_col);
      write_csr(REG_THRESHOLD, CSR_DATA_W'(thr));
      write_csr(REG_WIDTH, CSR_DATA_W'(w_raw));
      write_csr(REG_HEIGHT, CSR_DATA_W'(h_raw));
      w = eff_width(w_raw);
      frame_len = w * eff_height(h_raw);
      // per-column base levels so that stripes give real gradients
      for (int i = 0; i < LINE_DEPTH; i++)
         column_level[i] = ($urandom_range(2) == 0) ? 8'h00 :
                           ($urandom_range(1) == 1) ? 8'hFF : PIX_W'($urandom_range(255));
      for (int i = 0; i < n_items; i++) begin
         it.sof = (i == 0 && sof_first) || ($urandom_range(99) < noise_pct) ||
                  (aligned && i > 0 && i % frame_len == 0 && $urandom_range(1) == 1);
         if (it.sof) gc = 0;
         case (style)
            0: it.level = PIX_W'($urandom_range(255));
            1: begin
               v = int'(column_level[gc]) + int'($urandom_range(20)) - 10;
               if (v < 0) v = 0;
               if (v > 255) v = 255;
               it.level = PIX_W'(v);
            end
            default: it.level = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
         endcase
         pixel_q.insert(pixel_q.size(), it);
         gc = (gc + 1) % w;
      end
      wait_drained();
   endtask

   task automatic random_phase();
      logic [THR_W-1:0] thr;
      logic [FW_W-1:0]  w_raw;
      logic [ROW_W-1:0] h_raw;
      bit sof_first;
      int cur_eff, w, hh, n, pick;
      pick = $urandom_range(9);
      thr = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : THR_W'($urandom_range(120));
      pick = $urandom_range(9);
      h_raw = (pick == 0) ? ROW_W'($urandom_range(2)) :
              (pick == 1) ? 12'hFFF : ROW_W'($urandom_range(MIN_DIM, 8));
      w_raw = ($urandom_range(7) == 0) ? FW_W'($urandom_range(2))
                                      : FW_W'($urandom_range(MIN_DIM, SMALL_DIM));
      sof_first = ($urandom_range(3) == 0);
      cur_eff = eff_width(width_setting);
      // widening inside a frame would read line-store columns not yet written
      if (!sof_first && !(cur_row == 0 && cur_col == 0) && eff_width(w_raw) > cur_eff)
         w_raw = FW_W'($urandom_range(MIN_DIM, (cur_eff > SMALL_DIM) ? SMALL_DIM : cur_eff));
      w = eff_width(w_raw);
      hh = eff_height(h_raw);
      if (hh > 8) hh = 8;
      n = int'($urandom_range(1, 2)) * w * hh + int'($urandom_range(0, w * hh - 1));
      run_phase(thr, w_raw, h_raw, n, sof_first, int'($urandom_range(2)), 2);
   endtask

   initial begin
      thr_setting    = THRESHOLD_RESET;
      width_setting  = WIDTH_RESET;
      height_setting = HEIGHT_RESET;
      cur_row        = '0;
      cur_col        = '0;
      colsum_prev[0] = '0;
      colsum_prev[1] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      send_idle_pct = 23;
      recv_idle_pct = 67;

      // reset threshold and height on narrow rows
      write_csr(REG_WIDTH, CSR_DATA_W'(INTRO_WIDTH));
      for (int k = 0; k < INTRO_WIDTH * INTRO_ROWS; k++)
         push_pixel(PIX_W'($urandom_range(255)), k == 0);
      wait_drained();

      // sizes below the minimum act as 3x3; threshold zero
      write_csr(REG_THRESHOLD, '0);
      write_csr(REG_WIDTH, 12'd2);
      write_csr(REG_HEIGHT, '0);
      push_frame3({8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0}, 1'b1);
      // next frame by wrap alone, flat so the difference is exactly zero
      push_frame3('0, 1'b0);
      // frame start after two pixels of a frame
      push_pixel(8'd17, 1'b0);
      push_pixel(8'd200, 1'b0);
      // difference of one just exceeds a zero threshold
      push_frame3({8'd3, 8'd9, 8'd2, 8'd3, 8'd9, 8'd2, 8'd3, 8'd9, 8'd2}, 1'b1);
      wait_drained();
      // largest possible difference does not exceed the top threshold
      write_csr(REG_THRESHOLD, 12'd255);
      push_frame3({8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0}, 1'b1);
      wait_drained();

      // random frames under three idle patterns
      for (int k = 0; k < 18; k++) begin
         if (k == 6) begin
            send_idle_pct = 67;
            recv_idle_pct = 23;
         end
         if (k == 12) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_phase();
      end

      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> column_average_edge_detector.f
+incdir+hw/rtl
hw/rtl/caed_pkg.sv
hw/rtl/caed_ram.sv
hw/rtl/column_average_edge_detector.sv
hw/rtl/caed_checker.sv
bench/tb_top.sv
